[rtl/fte_pkg.sv]
// ----------------------------------------------------------------------------
// fte_pkg - shared types and constants of the flow template extractor
// codes, header sizes and the result bundle passed from parser to serialiser
// ----------------------------------------------------------------------------
package fte_pkg;

    localparam int MAX_PACKET_BYTES_DEF = 8192;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

    // export versions
    localparam logic [7:0] VER_V9    = 8'd9;
    localparam logic [7:0] VER_IPFIX = 8'd10;

    // packet header sizes in bytes
    localparam logic [4:0] HDR_V9    = 5'd20;
    localparam logic [4:0] HDR_IPFIX = 5'd16;

    // template flowset ids
    localparam logic [15:0] FSID_V9_TPL    = 16'd0;
    localparam logic [15:0] FSID_V9_OPT    = 16'd1;
    localparam logic [15:0] FSID_IPFIX_TPL = 16'd2;
    localparam logic [15:0] FSID_IPFIX_OPT = 16'd3;

    // header field patched at packet end
    localparam logic [15:0] PATCH_OFFSET = 16'd2;

    // flowset header size
    localparam logic [15:0] FS_HDR_LEN = 16'd4;

    // result kinds
    localparam logic [1:0] KIND_KEEP  = 2'd0;
    localparam logic [1:0] KIND_PATCH = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    // done status codes
    localparam logic [1:0] ST_FOUND    = 2'd0;
    localparam logic [1:0] ST_NONE     = 2'd1;
    localparam logic [1:0] ST_REJECTED = 2'd2;
    localparam logic [1:0] ST_SHORT    = 2'd3;

    // all results caused by one input item, in output order:
    // kept bytes, then optional patch, then optional done
    typedef struct packed {
        logic [2:0]  keep_cnt;
        logic [15:0] keep_off;
        logic [31:0] keep_data;   // next byte to send in the top byte
        logic        has_patch;
        logic [15:0] patch_val;
        logic        has_done;
        logic [15:0] done_val;
        logic [1:0]  done_status;
    } bundle_t;

endpackage

[rtl/fte_parser.sv]
// ----------------------------------------------------------------------------
// fte_parser - per-byte packet walk
// holds the packet walk state and turns each accepted byte into a result bundle
// ----------------------------------------------------------------------------
module fte_parser
    import fte_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [7:0]  data_byte,
    input  logic [7:0]  version,
    input  logic [15:0] packet_length,
    input  logic        last_byte,
    output bundle_t     bundle
);

    logic [15:0] pos_reg,     pos_next;
    logic [15:0] off_reg,     off_next;
    logic [31:0] win_reg,     win_next;
    logic [15:0] rem_reg,     rem_next;
    logic        copy_reg,    copy_next;
    logic [15:0] seen_reg,    seen_next;
    logic [15:0] tk_reg,      tk_next;
    logic [16:0] limit_reg,   limit_next;
    logic        v9_reg,      v9_next;
    logic        badver_reg,  badver_next;
    logic        stop_reg,    stop_next;
    logic        rej_reg,     rej_next;
    logic [1:0]  fill_reg,    fill_next;

    logic        first;
    logic        ver_ok;
    logic        bad_ver;
    logic        cur_v9;
    logic        cur_badver;
    logic        cur_rej;
    logic [4:0]  hdr_len;
    logic        take;
    logic        in_hdr;
    logic [31:0] win_shift;
    logic [15:0] fs_id;
    logic [15:0] fs_len;
    logic [15:0] fs_start;
    logic [15:0] fs_room;
    logic        len_bad;
    logic        limit_hit;
    logic        is_tpl;

    assign first   = (pos_reg == 16'd0);
    assign ver_ok  = (version == VER_V9) || (version == VER_IPFIX);
    assign bad_ver = !ver_ok || (packet_length == 16'd0)
                     || ({1'b0, packet_length} > 17'(MAX_PACKET_BYTES));

    // version and rejection are decided on the first byte of a packet
    assign cur_v9     = first ? (!bad_ver && (version == VER_V9)) : v9_reg;
    assign cur_badver = first ? bad_ver : badver_reg;
    assign hdr_len    = cur_v9 ? HDR_V9 : HDR_IPFIX;
    assign cur_rej    = first ? (bad_ver || (packet_length < {11'd0, hdr_len})) : rej_reg;

    assign take   = !cur_rej && (pos_reg < packet_length);
    assign in_hdr = (pos_reg < {11'd0, hdr_len});

    assign win_shift = {win_reg[23:0], data_byte};
    assign fs_id     = win_shift[31:16];
    assign fs_len    = win_shift[15:0];
    assign fs_start  = pos_reg - 16'd3;
    assign fs_room   = packet_length - fs_start;
    assign len_bad   = (fs_len < FS_HDR_LEN)
                       || (({1'b0, fs_len} + {1'b0, FS_HDR_LEN}) > {1'b0, fs_room});
    assign limit_hit = cur_v9 && ({1'b0, seen_reg} >= limit_reg);
    assign is_tpl    = cur_v9 ? ((fs_id == FSID_V9_TPL) || (fs_id == FSID_V9_OPT))
                              : ((fs_id == FSID_IPFIX_TPL) || (fs_id == FSID_IPFIX_OPT));

    always_comb
    begin
        pos_next    = (pos_reg == 16'hFFFF) ? pos_reg : pos_reg + 16'd1;
        off_next    = off_reg;
        win_next    = win_reg;
        rem_next    = rem_reg;
        copy_next   = copy_reg;
        seen_next   = seen_reg;
        tk_next     = tk_reg;
        limit_next  = limit_reg;
        v9_next     = cur_v9;
        badver_next = cur_badver;
        stop_next   = stop_reg;
        rej_next    = cur_rej;
        fill_next   = fill_reg;

        bundle = '0;
        bundle.keep_off = off_reg;

        if (take)
        begin
            if (in_hdr)
            begin
                // packet header is copied as it stands
                bundle.keep_cnt  = 3'd1;
                bundle.keep_data = {data_byte, 24'd0};
                off_next = off_reg + 16'd1;
                win_next = win_shift;
                if (cur_v9 && (pos_reg == 16'd3))
                begin
                    limit_next = {1'b0, win_shift[15:0]} + 17'd1;
                end
                if (pos_reg == ({11'd0, hdr_len} - 16'd1))
                begin
                    win_next  = '0;
                    fill_next = '0;
                end
            end
            else if (!stop_reg)
            begin
                if (rem_reg != 16'd0)
                begin
                    // flowset body
                    if (copy_reg)
                    begin
                        bundle.keep_cnt  = 3'd1;
                        bundle.keep_data = {data_byte, 24'd0};
                        off_next = off_reg + 16'd1;
                    end
                    rem_next = rem_reg - 16'd1;
                end
                else
                begin
                    // gathering a flowset header
                    win_next = win_shift;
                    if (fill_reg != 2'd3)
                    begin
                        fill_next = fill_reg + 2'd1;
                    end
                    else
                    begin
                        fill_next = '0;
                        if (limit_hit || len_bad)
                        begin
                            stop_next = 1'b1;
                        end
                        else
                        begin
                            if (is_tpl)
                            begin
                                bundle.keep_cnt  = 3'd4;
                                bundle.keep_data = win_shift;
                                off_next = off_reg + 16'd4;
                                if (tk_reg != 16'hFFFF)
                                begin
                                    tk_next = tk_reg + 16'd1;
                                end
                            end
                            copy_next = is_tpl;
                            rem_next  = fs_len - FS_HDR_LEN;
                            if (seen_reg != 16'hFFFF)
                            begin
                                seen_next = seen_reg + 16'd1;
                            end
                        end
                    end
                end
            end
        end

        if (last_byte)
        begin
            bundle.has_done = 1'b1;
            if (cur_rej)
            begin
                bundle.done_status = cur_badver ? ST_REJECTED : ST_SHORT;
            end
            else if (tk_next != 16'd0)
            begin
                bundle.has_patch   = 1'b1;
                bundle.patch_val   = cur_v9 ? tk_next : off_next;
                bundle.done_val    = off_next;
                bundle.done_status = ST_FOUND;
            end
            else
            begin
                bundle.done_status = ST_NONE;
            end

            // back to the start of a packet
            pos_next    = '0;
            off_next    = '0;
            win_next    = '0;
            rem_next    = '0;
            copy_next   = 1'b0;
            seen_next   = '0;
            tk_next     = '0;
            limit_next  = '0;
            v9_next     = 1'b0;
            badver_next = 1'b0;
            stop_next   = 1'b0;
            rej_next    = 1'b0;
            fill_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            off_reg    <= '0;
            win_reg    <= '0;
            rem_reg    <= '0;
            copy_reg   <= 1'b0;
            seen_reg   <= '0;
            tk_reg     <= '0;
            limit_reg  <= '0;
            v9_reg     <= 1'b0;
            badver_reg <= 1'b0;
            stop_reg   <= 1'b0;
            rej_reg    <= 1'b0;
            fill_reg   <= '0;
        end
        else if (in_valid)
        begin
            pos_reg    <= pos_next;
            off_reg    <= off_next;
            win_reg    <= win_next;
            rem_reg    <= rem_next;
            copy_reg   <= copy_next;
            seen_reg   <= seen_next;
            tk_reg     <= tk_next;
            limit_reg  <= limit_next;
            v9_reg     <= v9_next;
            badver_reg <= badver_next;
            stop_reg   <= stop_next;
            rej_reg    <= rej_next;
            fill_reg   <= fill_next;
        end
    end

    // end of packet always returns the walk to its start
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && last_byte |=> (pos_reg == 16'd0) && (tk_reg == 16'd0) && !stop_reg)
        else $error("walk state not cleared after packet end");

    // byte position steps by one on every accepted byte but the last, until it saturates
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !last_byte && (pos_reg != 16'hFFFF) |=> pos_reg == $past(pos_reg) + 16'd1)
        else $error("byte position out of step");

    // the walk only halts between flowsets
    assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg != 16'd0) |-> !stop_reg)
        else $error("walk halted inside a flowset body");

endmodule

[rtl/fte_serializer.sv]
// ----------------------------------------------------------------------------
// fte_serializer - result bundle to single item stream
// holds one bundle and sends its results through an output register
// ----------------------------------------------------------------------------
module fte_serializer
    import fte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  bundle_t     bundle,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  out_kind,
    output logic [15:0] out_offset,
    output logic [15:0] out_value,
    output logic [1:0]  out_status,
    output logic        out_last
);

    bundle_t     bnd_reg;
    logic        out_valid_reg;
    logic [1:0]  out_kind_reg;
    logic [15:0] out_off_reg;
    logic [15:0] out_val_reg;
    logic [1:0]  out_status_reg;
    logic        out_last_reg;

    logic        bnd_busy;
    logic        out_load;
    logic        drain;
    logic        last_elem;

    assign bnd_busy  = (bnd_reg.keep_cnt != 3'd0) || bnd_reg.has_patch || bnd_reg.has_done;
    assign out_load  = !out_valid_reg || out_ready;
    assign drain     = bnd_busy && out_load;
    assign last_elem = (bnd_reg.keep_cnt == 3'd1 && !bnd_reg.has_patch && !bnd_reg.has_done)
                       || (bnd_reg.keep_cnt == 3'd0 && bnd_reg.has_patch && !bnd_reg.has_done)
                       || (bnd_reg.keep_cnt == 3'd0 && !bnd_reg.has_patch && bnd_reg.has_done);

    // a new bundle may enter while its last result moves to the output
    assign in_ready = !bnd_busy || (out_load && last_elem);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bnd_reg <= '0;
        end
        else if (load)
        begin
            bnd_reg <= bundle;
        end
        else if (drain)
        begin
            if (bnd_reg.keep_cnt != 3'd0)
            begin
                bnd_reg.keep_cnt  <= bnd_reg.keep_cnt - 3'd1;
                bnd_reg.keep_off  <= bnd_reg.keep_off + 16'd1;
                bnd_reg.keep_data <= {bnd_reg.keep_data[23:0], 8'd0};
            end
            else if (bnd_reg.has_patch)
            begin
                bnd_reg.has_patch <= 1'b0;
            end
            else
            begin
                bnd_reg.has_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= bnd_busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (drain)
        begin
            out_last_reg <= last_elem;
            if (bnd_reg.keep_cnt != 3'd0)
            begin
                out_kind_reg   <= KIND_KEEP;
                out_off_reg    <= bnd_reg.keep_off;
                out_val_reg    <= {8'd0, bnd_reg.keep_data[31:24]};
                out_status_reg <= ST_FOUND;
            end
            else if (bnd_reg.has_patch)
            begin
                out_kind_reg   <= KIND_PATCH;
                out_off_reg    <= PATCH_OFFSET;
                out_val_reg    <= bnd_reg.patch_val;
                out_status_reg <= ST_FOUND;
            end
            else
            begin
                out_kind_reg   <= KIND_DONE;
                out_off_reg    <= 16'd0;
                out_val_reg    <= bnd_reg.done_val;
                out_status_reg <= bnd_reg.done_status;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_kind   = out_kind_reg;
    assign out_offset = out_off_reg;
    assign out_value  = out_val_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

    // a done result always closes the results of its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_kind_reg == KIND_DONE) |-> out_last_reg)
        else $error("done result not marked last");

    // a patch is always followed by its done result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_kind_reg == KIND_PATCH) |-> !out_last_reg)
        else $error("patch result marked last");

    // no bundle ever carries more than one flowset header of kept bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        bnd_reg.keep_cnt <= 3'd4)
        else $error("kept byte count out of range");

    // a bundle is never overwritten while results remain behind its last one
    assert property (@(posedge clk) disable iff (!rst_n)
        load && bnd_busy |-> drain && last_elem)
        else $error("bundle overwritten before drained");

endmodule

[rtl/flow_template_extractor_top.sv]
// ----------------------------------------------------------------------------
// flow_template_extractor_top - template flowset filter for flow export packets
// keeps the header and template flowsets of v9 and ipfix packets, patches
// the header count or length field and reports the kept length
// ----------------------------------------------------------------------------
// The block takes one packet byte per item on the slave side and keeps a
// running walk of the packet: the 20-byte (v9) or 16-byte (ipfix) header is
// passed on, then each flowset header is gathered and template flowsets
// (ids 0 and 1 for v9, 2 and 3 for ipfix) are passed on while others are
// skipped. The walk halts on a flowset length below 4, a length that plus 4
// overruns the packet from the flowset start, or for v9 once the header
// count plus one flowsets are taken. On the byte marked tlast the block
// sends a patch for offset 2 (template count for v9, kept length for ipfix)
// when templates were kept, then a done item with a status and, in that case,
// the kept length. The results of each byte (up to six) leave one per
// cycle through a single output register while m_tready is high, which sets
// the rate: a byte with at most one result is taken every cycle unless the
// output stalls, one that completes a kept flowset header (four results) or
// ends the packet (up to six) holds the input until all but one have left.
module flow_template_extractor_top
    import fte_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // data_byte[7:0], version[15:8], packet_length[31:16]
    input  logic                 s_tlast,   // last_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // offset[15:0], value[31:16], status[33:32], zero fill
    output logic [1:0]           m_tuser,   // kind
    output logic                 m_tlast    // last_result
);

    logic        accept;
    bundle_t     bundle;
    logic [15:0] res_offset;
    logic [15:0] res_value;
    logic [1:0]  res_status;

    // an item is taken whenever the serialiser can hold its bundle
    assign accept = s_tvalid && s_tready;

    fte_parser #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (accept),
        .data_byte     (s_tdata[7:0]),
        .version       (s_tdata[15:8]),
        .packet_length (s_tdata[31:16]),
        .last_byte     (s_tlast),
        .bundle        (bundle)
    );

    fte_serializer u_serializer (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .bundle     (bundle),
        .in_ready   (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_kind   (m_tuser),
        .out_offset (res_offset),
        .out_value  (res_value),
        .out_status (res_status),
        .out_last   (m_tlast)
    );

    // result fields packed from the lowest bit, zero filled to whole bytes
    assign m_tdata = {6'd0, res_status, res_value, res_offset};

endmodule
